// File: rtl/whse_pkg.sv
// Wheel pulse speed estimator: shared constants, register codes and divider types.
// No dependencies.
package whse_pkg;

    localparam int MAX_WINDOW_DEF = 32;
    localparam int RING_W         = 72;     // {stamp[63:0], count[7:0]}
    localparam int DIV_W          = 64;
    localparam int SCALE_W        = 20;
    localparam logic [SCALE_W-1:0] SCALE_UM_NS_TO_MM_S = SCALE_W'(1000000);

    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_DIST_UM    = 2'd1;
    localparam logic [1:0] REG_MIN_INT    = 2'd2;
    localparam logic [1:0] REG_STOP_TO    = 2'd3;

    localparam logic [5:0]  RST_WINDOW_LEN = 6'd32;
    localparam logic [19:0] RST_DIST_UM    = 20'd1000;
    localparam logic [31:0] RST_MIN_INT    = 32'd0;
    localparam logic [35:0] RST_STOP_TO    = 36'd1000000000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

// File: rtl/whse_div.sv
// Wheel pulse speed estimator: shared restoring divider, one quotient bit per cycle.
// Depends on whse_pkg.
module whse_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  whse_pkg::t_div_req i_req,
    output whse_pkg::t_div_rsp o_rsp
);
    import whse_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = !diff[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// File: rtl/whse_ring.sv
// Wheel pulse speed estimator: sample ring memory, one write and one registered read port.
// Depends on whse_pkg.
module whse_ring #(
    parameter int DEPTH = whse_pkg::MAX_WINDOW_DEF + 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [whse_pkg::RING_W-1:0] i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    output logic [whse_pkg::RING_W-1:0] o_rd_data
);
    import whse_pkg::*;

    logic [RING_W-1:0] r_mem [DEPTH];
    logic [RING_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// File: rtl/wheel_pulse_speed_estimator_core.sv
// Wheel pulse speed estimator top: APB registers, sequencer, counters, output register.
// Depends on whse_pkg, whse_div, whse_ring.
//
//  channel  direction  payload
//  s        in         tuser: opcode; tdata: time_ns, pulse_count
//  m        out        tuser: pulse_accepted; tdata: speed, interval, rejected, accepted
//  apb      in/out     four config registers at 8*i
//
// A pulse event runs its check, the mean-interval divide when it applies and a drop
// step per dropped sample. A query may return zero early after its check, else it runs
// the window divide, and a second divide when the elapsed-time cap is also computed; the
// shared 64-bit serial divider does each divide. Sync reset clears the window and counters.
// s_tready is high only while the sequencer is idle; one finished transaction may
// wait in the output register, and a full output register holds the sequencer.
module wheel_pulse_speed_estimator_core #(
    parameter int MAX_WINDOW = whse_pkg::MAX_WINDOW_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [71:0]  i_s_tdata,   // time_ns[63:0], pulse_count[71:64]
    input  logic         i_s_tuser,   // opcode
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,   // speed[31:0], interval[67:32], rejected[99:68],
                                      // accepted[131:100], zero pad
    output logic         o_m_tuser,   // pulse_accepted
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import whse_pkg::*;

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_WINDOW + 2);
    localparam int SW    = $clog2(MAX_WINDOW * 255 + 1);

    localparam logic [3:0] S_IDLE = 4'd0,  S_P_CHK = 4'd1,  S_P_DS = 4'd2,  S_P_DW = 4'd3,
                           S_P_DROP = 4'd4, S_P_DRD = 4'd5, S_Q_CHK = 4'd6, S_Q_MUL = 4'd7,
                           S_Q_DS1 = 4'd8, S_Q_DW1 = 4'd9, S_Q_DS2 = 4'd10, S_Q_DW2 = 4'd11,
                           S_Q_SAT = 4'd12, S_DONE = 4'd13;

    logic [3:0]  r_state;
    logic [5:0]  r_win;
    logic [19:0] r_dist;
    logic [31:0] r_mini;
    logic [35:0] r_stop;

    logic [IW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [SW-1:0] r_sum;
    logic          r_seen;
    logic [63:0]   r_newest;
    logic [35:0]   r_mean;
    logic [31:0]   r_rej;
    logic [31:0]   r_accc;

    logic          r_op;
    logic [63:0]   r_t;
    logic [7:0]    r_c;
    logic [63:0]   r_gap;
    logic          r_late;
    logic [39:0]   r_minc;
    logic [SW+19:0] r_prod;
    logic [63:0]   r_num;
    logic [63:0]   r_den;
    logic [63:0]   r_v;
    logic          r_acc;
    logic [31:0]   r_speed;

    logic          r_ovalid;
    logic          r_o_acc;
    logic [31:0]   r_o_speed;
    logic [35:0]   r_o_mean;
    logic [31:0]   r_o_rej;
    logic [31:0]   r_o_accc;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    logic [IW-1:0]     head_inc;
    logic [IW-1:0]     wr_addr;
    logic [IW:0]       head_fill;
    logic [FW-1:0]     w_eff;
    logic [RING_W-1:0] rd_data;
    logic              wr_en;
    logic [7:0]        c_eff;
    logic [63:0]       span;
    logic [32:0]       acc_sum;
    logic              cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= RST_WINDOW_LEN;
            r_dist <= RST_DIST_UM;
            r_mini <= RST_MIN_INT;
            r_stop <= RST_STOP_TO;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_WINDOW_LEN: r_win  <= pwdata[5:0];
                REG_DIST_UM:    r_dist <= pwdata[19:0];
                REG_MIN_INT:    r_mini <= pwdata[31:0];
                REG_STOP_TO:    r_stop <= pwdata[35:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_WINDOW_LEN: prdata = {58'd0, r_win};
            REG_DIST_UM:    prdata = {44'd0, r_dist};
            REG_MIN_INT:    prdata = {32'd0, r_mini};
            REG_STOP_TO:    prdata = {28'd0, r_stop};
            default:        prdata = '0;
        endcase
    end

    // datapath helpers
    always_comb begin
        if (r_win == 6'd0) begin
            w_eff = FW'(1);
        end else if (32'(r_win) > 32'(MAX_WINDOW)) begin
            w_eff = FW'(MAX_WINDOW);
        end else begin
            w_eff = FW'(r_win);
        end
    end

    assign head_inc  = (32'(r_head) == DEPTH - 1) ? '0 : r_head + IW'(1);
    assign head_fill = (IW + 1)'(r_head) + (IW + 1)'(r_fill);
    assign wr_addr   = (32'(head_fill) >= DEPTH) ? IW'(32'(head_fill) - DEPTH)
                                                  : IW'(head_fill);
    assign c_eff     = (i_s_tdata[71:64] == 8'd0) ? 8'd1 : i_s_tdata[71:64];
    assign span      = r_newest - rd_data[RING_W-1:8];
    assign acc_sum   = {1'b0, r_accc} + 33'(r_c);
    assign wr_en     = (r_state == S_P_DROP) &&
                       !((FW + 1)'(r_fill) >= (FW + 1)'(w_eff) + (FW + 1)'(1));

    assign div_req.start = (r_state == S_P_DS) || (r_state == S_Q_DS1) ||
                           (r_state == S_Q_DS2);
    assign div_req.num   = r_num;
    assign div_req.den   = r_den;

    whse_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    whse_ring #(.DEPTH(DEPTH)) u_ring (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data({r_t, r_c}),
        .i_rd_addr((r_state == S_P_DROP) ? head_inc : r_head),
        .o_rd_data(rd_data)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_seen   <= 1'b0;
            r_newest <= '0;
            r_mean   <= '0;
            r_rej    <= '0;
            r_accc   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= i_s_tuser ? S_Q_CHK : S_P_CHK;
                    end
                end
                S_P_CHK: begin
                    if (r_seen && (!r_late || r_gap < 64'(r_minc))) begin
                        if (r_rej != 32'hFFFF_FFFF) begin
                            r_rej <= r_rej + 32'd1;
                        end
                        r_state <= S_DONE;
                    end else if (r_seen && r_gap > {28'd0, r_stop}) begin
                        r_head  <= '0;
                        r_fill  <= '0;
                        r_sum   <= '0;
                        r_mean  <= '0;
                        r_state <= S_P_DROP;
                    end else if (r_seen) begin
                        r_state <= S_P_DS;
                    end else begin
                        r_state <= S_P_DROP;
                    end
                end
                S_P_DS: r_state <= S_P_DW;
                S_P_DW: begin
                    if (div_rsp.done) begin
                        r_mean  <= div_rsp.quo[35:0];
                        r_state <= S_P_DROP;
                    end
                end
                S_P_DROP: begin
                    if (wr_en) begin
                        if (r_fill != '0) begin
                            r_sum <= r_sum + SW'(r_c);
                        end
                        r_fill   <= r_fill + FW'(1);
                        r_seen   <= 1'b1;
                        r_newest <= r_t;
                        r_accc   <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_P_DRD;
                    end
                end
                S_P_DRD: begin
                    r_sum   <= r_sum - SW'(rd_data[7:0]);
                    r_head  <= head_inc;
                    r_fill  <= r_fill - FW'(1);
                    r_state <= S_P_DROP;
                end
                S_Q_CHK: begin
                    if (r_fill < FW'(2) || (r_late && r_gap > {28'd0, r_stop}) ||
                        span == 64'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_Q_MUL;
                    end
                end
                S_Q_MUL: r_state <= S_Q_DS1;
                S_Q_DS1: r_state <= S_Q_DW1;
                S_Q_DW1: begin
                    if (div_rsp.done) begin
                        r_state <= r_late ? S_Q_DS2 : S_Q_SAT;
                    end
                end
                S_Q_DS2: r_state <= S_Q_DW2;
                S_Q_DW2: begin
                    if (div_rsp.done) begin
                        r_state <= S_Q_SAT;
                    end
                end
                S_Q_SAT: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_s_tuser;
                r_t     <= i_s_tdata[63:0];
                r_c     <= c_eff;
                r_gap   <= i_s_tdata[63:0] - r_newest;
                r_late  <= i_s_tdata[63:0] > r_newest;
                r_minc  <= 40'(r_mini) * 40'(c_eff);
                r_acc   <= 1'b0;
                r_speed <= '0;
            end
            S_P_CHK: begin
                r_num <= r_gap;
                r_den <= 64'(r_c);
            end
            S_P_DROP: begin
                if (wr_en) begin
                    r_acc <= 1'b1;
                end
            end
            S_Q_CHK: begin
                r_den  <= span;
                r_prod <= (SW + 20)'(r_sum) * (SW + 20)'(r_dist);
            end
            S_Q_MUL: r_num <= 64'(r_prod * 64'(SCALE_UM_NS_TO_MM_S));
            S_Q_DW1: begin
                if (div_rsp.done) begin
                    r_v   <= div_rsp.quo;
                    r_num <= 64'(40'(r_dist) * 40'(SCALE_UM_NS_TO_MM_S));
                    r_den <= r_gap;
                end
            end
            S_Q_DW2: begin
                if (div_rsp.done && div_rsp.quo < r_v) begin
                    r_v <= div_rsp.quo;
                end
            end
            S_Q_SAT: r_speed <= (r_v[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_v[31:0];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
            r_o_acc   <= r_acc && !r_op;
            r_o_speed <= r_speed;
            r_o_mean  <= r_mean;
            r_o_rej   <= r_rej;
            r_o_accc  <= r_accc;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_o_acc;
    assign o_m_tdata  = {4'd0, r_o_accc, r_o_rej, r_o_mean, r_o_speed};

endmodule
